### hdl/assert_macros.svh
// Assertion macros for the RTL of the rectangle table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every rising edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property check failed");
// Checks that a condition is never true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hdl/rtoq_pkg.sv
// Types, constants and helper functions of the rectangle table overlap query block.
package rtoq_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = 10;
  localparam int SLOT_BITS  = 6;
  localparam int KIND_BITS  = 2;
  localparam int CMD_BITS   = 2;

  // Index width of the slot table.
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Edge width: a coordinate plus a size never overflows this.
  localparam int EDGE_W = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS + 1) + 1;

  typedef logic [SLOT_W-1:0]            slot_idx_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WRITE     = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_CLEAR_BLK = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  // One stored rectangle.
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    coord_t               x;
    coord_t               y;
    size_t                w;
    size_t                h;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Query edges, worked out once when the query beat is accepted.
  typedef struct packed {
    edge_t left_blk;
    edge_t left_bomb;
    edge_t top_blk;
    edge_t top_bomb;
    edge_t right;
    edge_t bottom;
  } query_t;

  // Bit one of the kind marks a bomb; kind three counts as a bomb too.
  function automatic logic is_bomb(input logic [KIND_BITS-1:0] k);
    return k[1];
  endfunction

  function automatic edge_t coord_edge(input coord_t c);
    return edge_t'(c);
  endfunction

  function automatic edge_t size_edge(input size_t s);
    return edge_t'(s);
  endfunction

endpackage

### hdl/rtoq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module rtoq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/rtoq_match.sv
// Strict overlap test of one stored rectangle against the query edges.
module rtoq_match
  import rtoq_pkg::*;
(
  input  query_t query,
  input  entry_t entry,
  output logic   hit
);

  edge_t ent_left;
  edge_t ent_top;
  edge_t ent_right;
  edge_t ent_bottom;
  edge_t q_left;
  edge_t q_top;

  // Entry edges at full width.
  always_comb begin
    ent_left   = coord_edge(entry.x);
    ent_top    = coord_edge(entry.y);
    ent_right  = ent_left + size_edge(entry.w);
    ent_bottom = ent_top + size_edge(entry.h);
  end

  // Bombs are tested without the inset.
  always_comb begin
    q_left = is_bomb(entry.kind) ? query.left_bomb : query.left_blk;
    q_top  = is_bomb(entry.kind) ? query.top_bomb  : query.top_blk;
  end

  // Edges that only touch do not count.
  assign hit = (ent_bottom > q_top) && (ent_top < query.bottom) &&
               (ent_right > q_left) && (ent_left < query.right);

endmodule

### hdl/rect_table_overlap_query.sv
// Top level of the rectangle table overlap query block: control, flags and output beat.
//
// The block keeps a table of rectangles in slots. Each input beat carries a
// command: write a slot, clear a slot, clear every block slot while keeping
// bombs, or query a rectangle. Every input beat yields exactly one output beat
// with the hit flag, which is zero for all commands other than a query.
// Both channels use valid and ready; a beat moves when both are high.
// Write, clear and clear-all take one cycle: the output beat is valid at the
// edge after acceptance, and the next input beat can be taken in that cycle.
// A query reads the rectangle memory one slot per cycle over all 64 slots, and
// the block takes no new beat until the scan has finished and its output beat
// is in the output register; the single read port of the memory sets this
// pace. Valid bits and bomb flags sit in flip-flops next to the memory.
// Reset clears all valid bits and the handshake state; the table is empty
// right after reset and no clearing pass is needed. While the receiver holds
// out_ready low, the output beat waits in its register and no new input beat
// is taken.
module rect_table_overlap_query
  import rtoq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_BITS-1:0]   in_cmd,
  input  logic [SLOT_BITS-1:0]  in_slot,
  input  logic [KIND_BITS-1:0]  in_kind,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic [SIZE_BITS-1:0]  in_width,
  input  logic [SIZE_BITS-1:0]  in_height,
  input  logic [SIZE_BITS-1:0]  in_inset_x,
  input  logic [SIZE_BITS-1:0]  in_inset_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(NUM_SLOTS - 1);

  state_t         state_r, state_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0] bomb_r;
  slot_idx_t      scan_addr_r, scan_addr_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic           rd_ent_vld_r;
  logic           rd_last_r;
  logic           hit_acc_r, hit_acc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_hit_r, out_hit_nxt;
  query_t         query_r;

  logic           accept;
  cmd_t           cmd;
  slot_idx_t      in_idx;
  logic           slot_ok;
  logic           mem_we;
  logic           mem_re;
  entry_t         wr_entry;
  logic [ENTRY_W-1:0] rd_word;
  entry_t         rd_entry;
  logic           match_hit;
  logic           cmp_hit;
  logic           finish;

  // Input handshake: one item at a time, output register free or draining.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(in_cmd);
  assign in_idx   = slot_idx_t'(in_slot);
  assign slot_ok  = (int'(in_slot) < NUM_SLOTS);

  // Rectangle memory: written on a slot write, read during a scan.
  assign mem_we = accept && (cmd == CMD_WRITE) && slot_ok;
  assign mem_re = (state_r == ST_SCAN);

  always_comb begin
    wr_entry.kind = in_kind;
    wr_entry.x    = in_pos_x;
    wr_entry.y    = in_pos_y;
    wr_entry.w    = in_width;
    wr_entry.h    = in_height;
  end

  rtoq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (in_idx),
    .wr_data (wr_entry),
    .rd_en   (mem_re),
    .rd_addr (scan_addr_r),
    .rd_data (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  rtoq_match u_match (
    .query (query_r),
    .entry (rd_entry),
    .hit   (match_hit)
  );

  // Compare stage in the cycle after the memory read.
  assign cmp_hit = rd_vld_r && rd_ent_vld_r && match_hit;
  assign finish  = rd_vld_r && rd_last_r;

  // Valid bit updates.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      unique case (cmd)
        CMD_WRITE: begin
          if (slot_ok) begin
            valid_nxt[in_idx] = 1'b1;
          end
        end
        CMD_CLEAR: begin
          if (slot_ok) begin
            valid_nxt[in_idx] = 1'b0;
          end
        end
        CMD_CLEAR_BLK: begin
          valid_nxt = valid_r & bomb_r;
        end
        CMD_QUERY: begin
          valid_nxt = valid_r;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // Sequencer for the scan.
  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    rd_vld_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (cmd == CMD_QUERY)) begin
          state_nxt     = ST_SCAN;
          scan_addr_nxt = '0;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (scan_addr_r == LAST_SLOT) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + slot_idx_t'(1);
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hit accumulation and the output register.
  always_comb begin
    hit_acc_nxt   = hit_acc_r | cmp_hit;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    if (accept) begin
      hit_acc_nxt = 1'b0;
      if (cmd != CMD_QUERY) begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b0;
      end
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit_acc_r | cmp_hit;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    hit_acc_r    <= hit_acc_nxt;
    out_hit_r    <= out_hit_nxt;
    rd_ent_vld_r <= valid_r[scan_addr_r];
    rd_last_r    <= (scan_addr_r == LAST_SLOT);
    if (mem_we) begin
      bomb_r[in_idx] <= is_bomb(in_kind);
    end
    if (accept && (cmd == CMD_QUERY)) begin
      query_r.left_blk  <= coord_edge(in_pos_x) + size_edge(in_inset_x);
      query_r.left_bomb <= coord_edge(in_pos_x);
      query_r.top_blk   <= coord_edge(in_pos_y) + size_edge(in_inset_y);
      query_r.top_bomb  <= coord_edge(in_pos_y);
      query_r.right     <= coord_edge(in_pos_x) + size_edge(in_width);
      query_r.bottom    <= coord_edge(in_pos_y) + size_edge(in_height);
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // A query starts a scan from slot zero.
  `ASSERT_PROP(a_query_scans, clk, rst_n,
    (accept && (cmd == CMD_QUERY)) |=> (state_r == ST_SCAN) && (scan_addr_r == '0))
  // Other commands answer in the next cycle with no hit.
  `ASSERT_PROP(a_cmd_answer, clk, rst_n,
    (accept && (cmd != CMD_QUERY)) |=> (out_valid_r && !out_hit_r))
  // The output register is empty during a scan.
  `ASSERT_NEVER(a_no_out_in_scan, clk, rst_n, (state_r == ST_SCAN) && out_valid_r)
  // Read data only arrives after a scan cycle.
  `ASSERT_PROP(a_read_from_scan, clk, rst_n, rd_vld_r |-> ($past(state_r) == ST_SCAN))
  // A scan finishes only in the drain state.
  `ASSERT_PROP(a_finish_drain, clk, rst_n, finish |-> (state_r == ST_DRAIN))

endmodule

### verif/rect_table_overlap_query_tb.sv
// Self-checking testbench for the rectangle table overlap query block.
module rect_table_overlap_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtoq_pkg::cmd_t;
  import rtoq_pkg::CMD_WRITE;
  import rtoq_pkg::CMD_CLEAR;
  import rtoq_pkg::CMD_CLEAR_BLK;
  import rtoq_pkg::CMD_QUERY;
  import rtoq_pkg::NUM_SLOTS;
  import rtoq_pkg::COORD_BITS;
  import rtoq_pkg::SIZE_BITS;
  import rtoq_pkg::SLOT_BITS;
  import rtoq_pkg::KIND_BITS;
  import rtoq_pkg::CMD_BITS;

  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN   = -COORD_MAX - 1;
  localparam int SIZE_MAX    = (1 << SIZE_BITS) - 1;
  localparam int RANDOM_CMDS = 1500;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;

  // One command beat as the driver presents it, plus its pacing.
  typedef struct packed {
    cmd_t                   cmd;
    logic [SLOT_BITS-1:0]   slot;
    logic [KIND_BITS-1:0]   kind;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [SIZE_BITS-1:0]   width;
    logic [SIZE_BITS-1:0]   height;
    logic [SIZE_BITS-1:0]   inset_x;
    logic [SIZE_BITS-1:0]   inset_y;
    int                     gap_after;
    logic                   drain;
  } cmd_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_BITS-1:0]    in_cmd = '0;
  logic [SLOT_BITS-1:0]   in_slot = '0;
  logic [KIND_BITS-1:0]   in_kind = '0;
  logic signed [COORD_BITS-1:0] in_pos_x = '0;
  logic signed [COORD_BITS-1:0] in_pos_y = '0;
  logic [SIZE_BITS-1:0]   in_width = '0;
  logic [SIZE_BITS-1:0]   in_height = '0;
  logic [SIZE_BITS-1:0]   in_inset_x = '0;
  logic [SIZE_BITS-1:0]   in_inset_y = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_hit;

  // Shadow copy of the slot table.
  bit                     shadow_live [NUM_SLOTS];
  bit [KIND_BITS-1:0]     shadow_kind [NUM_SLOTS];
  longint                 shadow_x [NUM_SLOTS];
  longint                 shadow_y [NUM_SLOTS];
  longint                 shadow_w [NUM_SLOTS];
  longint                 shadow_h [NUM_SLOTS];

  cmd_beat_t              cmd_backlog [$];
  logic                   hit_due [$];
  cmd_beat_t              live_beat;
  int                     tx_hold = 0;
  int                     rx_hold = 0;
  int                     tx_calm_left = 0;
  int                     rx_calm_left = 0;
  int                     beats_taken = 0;
  int                     total_beats = 0;
  int                     results_seen = 0;
  int                     mismatches = 0;
  int                     quiet_cycles = 0;
  int                     arena_centre = 0;
  logic                   drain_next = 1'b0;
  logic                   want_hit;
  int                     stall;

  rect_table_overlap_query u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_slot    (in_slot),
    .in_kind    (in_kind),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_width   (in_width),
    .in_height  (in_height),
    .in_inset_x (in_inset_x),
    .in_inset_y (in_inset_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] %s", $time, what);
    mismatches++;
  endtask

  // Applies one command to the shadow table and returns the hit it must produce.
  function automatic logic apply_table_cmd(input cmd_beat_t b);
    logic   hit;
    longint px, py, qw, qh, ql, qt, qr, qb, el, et, er, eb;
    hit = 1'b0;
    px = longint'($signed(b.pos_x));
    py = longint'($signed(b.pos_y));
    qw = b.width;
    qh = b.height;
    case (b.cmd)
      CMD_WRITE: begin
        if (b.slot < NUM_SLOTS) begin
          shadow_live[b.slot] = 1'b1;
          shadow_kind[b.slot] = b.kind;
          shadow_x[b.slot] = px;
          shadow_y[b.slot] = py;
          shadow_w[b.slot] = qw;
          shadow_h[b.slot] = qh;
        end
      end
      CMD_CLEAR: begin
        if (b.slot < NUM_SLOTS) shadow_live[b.slot] = 1'b0;
      end
      CMD_CLEAR_BLK: begin
        // Bit one of the kind marks a bomb, which survives.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!shadow_kind[i][1]) shadow_live[i] = 1'b0;
        end
      end
      default: begin
        qr = px + qw;
        qb = py + qh;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (shadow_live[i]) begin
            el = shadow_x[i];
            et = shadow_y[i];
            er = el + shadow_w[i];
            eb = et + shadow_h[i];
            // Bombs see the plain query box, blocks the inset one.
            if (shadow_kind[i][1]) begin
              ql = px;
              qt = py;
            end else begin
              ql = px + longint'(b.inset_x);
              qt = py + longint'(b.inset_y);
            end
            if (eb > qt && et < qb && er > ql && el < qr) hit = 1'b1;
          end
        end
      end
    endcase
    return hit;
  endfunction

  // Sender idle cycles after a beat, with stretches of back-to-back beats.
  function automatic int next_gap();
    if (tx_calm_left != 0) begin
      tx_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) tx_calm_left = $urandom_range(10, 50);
    return $urandom_range(0, 15);
  endfunction

  // Receiver stall cycles after a beat, with stretches of no stalls.
  function automatic int next_stall();
    if (rx_calm_left != 0) begin
      rx_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) rx_calm_left = $urandom_range(10, 50);
    return $urandom_range(0, 15);
  endfunction

  // Mostly near the current arena so that rectangles meet, sometimes anywhere.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    logic [31:0] r;
    int          v;
    r = $urandom;
    if ($urandom_range(0, 9) == 0) return r[COORD_BITS-1:0];
    v = arena_centre + int'($urandom_range(0, 600)) - 300;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [SIZE_BITS-1:0] rand_size(input int unsigned typical);
    logic [31:0] r;
    if ($urandom_range(0, 9) == 0) r = $urandom_range(0, SIZE_MAX);
    else r = $urandom_range(0, typical);
    return r[SIZE_BITS-1:0];
  endfunction

  function automatic cmd_beat_t mk_beat(input cmd_t c, input int slot, input int kind,
                                        input int x, input int y, input int w,
                                        input int h, input int ix, input int iy);
    cmd_beat_t b;
    b.cmd = c;
    b.slot = slot[SLOT_BITS-1:0];
    b.kind = kind[KIND_BITS-1:0];
    b.pos_x = x[COORD_BITS-1:0];
    b.pos_y = y[COORD_BITS-1:0];
    b.width = w[SIZE_BITS-1:0];
    b.height = h[SIZE_BITS-1:0];
    b.inset_x = ix[SIZE_BITS-1:0];
    b.inset_y = iy[SIZE_BITS-1:0];
    b.gap_after = 0;
    b.drain = 1'b0;
    return b;
  endfunction

  task automatic queue_beat(input cmd_beat_t b);
    cmd_beat_t q;
    q = b;
    q.gap_after = next_gap();
    q.drain = drain_next;
    drain_next = 1'b0;
    cmd_backlog.push_back(q);
    total_beats++;
  endtask

  // Driver: presents backlog beats, predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_hold <= 0;
    end else begin
      if (in_valid && in_ready) begin
        hit_due.push_back(apply_table_cmd(live_beat));
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_hold != 0) begin
          in_valid <= 1'b0;
          tx_hold <= tx_hold - 1;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && hit_due.size() != 0)) begin
          live_beat = cmd_backlog.pop_front();
          in_cmd <= live_beat.cmd;
          in_slot <= live_beat.slot;
          in_kind <= live_beat.kind;
          in_pos_x <= live_beat.pos_x;
          in_pos_y <= live_beat.pos_y;
          in_width <= live_beat.width;
          in_height <= live_beat.height;
          in_inset_x <= live_beat.inset_x;
          in_inset_y <= live_beat.inset_y;
          in_valid <= 1'b1;
          tx_hold <= live_beat.gap_after;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (hit_due.size() == 0) begin
        report_mismatch($sformatf("result %0d: hit=%b with no command outstanding",
                                  results_seen, out_hit));
      end else begin
        want_hit = hit_due.pop_front();
        if (out_hit !== want_hit)
          report_mismatch($sformatf("result %0d: hit=%b, predicted %b",
                                    results_seen, out_hit, want_hit));
      end
      results_seen++;
      stall = next_stall();
      out_ready <= (stall == 0);
      rx_hold <= stall;
    end else if (!out_ready) begin
      if (rx_hold <= 1) begin
        out_ready <= 1'b1;
        rx_hold <= 0;
      end else begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rect_table_overlap_query: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    cmd_beat_t   b;
    logic [31:0] r;

    // Directed: edge touching, zero size, insets, kinds, extremes, clears.
    queue_beat(mk_beat(CMD_QUERY, 0, 0, COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX,
                       SIZE_MAX, SIZE_MAX));
    queue_beat(mk_beat(CMD_WRITE, 0, 0, 0, 0, 100, 100, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 100, 0, 50, 50, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, -50, 0, 50, 100, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 0, -50, 100, 50, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 99, 99, 10, 10, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 10, 10, 0, 50, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 10, 10, 50, 0, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, -20, -20, 50, 50, 50, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, -20, -20, 50, 50, 10, 10));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 50, 50, 30, 30, 40, 0));
    queue_beat(mk_beat(CMD_WRITE, 63, 2, 500, 500, 40, 40, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 480, 480, 30, 30, 25, 25));
    queue_beat(mk_beat(CMD_WRITE, 5, 3, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, COORD_MIN + 1000, COORD_MIN + 1000, 30, 30,
                       100, 100));
    queue_beat(mk_beat(CMD_WRITE, 6, 1, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, COORD_MAX, COORD_MAX, 1, 1, 0, 0));
    queue_beat(mk_beat(CMD_WRITE, 7, 0, 200, 200, 0, 500, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 150, 150, 200, 200, 0, 0));
    queue_beat(mk_beat(CMD_CLEAR_BLK, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 510, 510, 5, 5, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, COORD_MAX, COORD_MAX, 1, 1, 0, 0));
    queue_beat(mk_beat(CMD_CLEAR, 63, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(mk_beat(CMD_CLEAR, 20, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, 510, 510, 5, 5, 0, 0));
    queue_beat(mk_beat(CMD_QUERY, 0, 0, COORD_MIN, COORD_MIN, 1, 1, 0, 0));
    queue_beat(mk_beat(CMD_CLEAR, 5, 0, 0, 0, 0, 0, 0, 0));

    // Random: clustered rectangles so that queries both hit and miss.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: arena_centre = 0;
          1: arena_centre = COORD_MIN;
          2: arena_centre = COORD_MAX;
          default: arena_centre = int'($urandom_range(0, 65535)) + COORD_MIN;
        endcase
      end
      // Let the block run dry now and then before the next beat.
      if (n % 300 == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 35) b.cmd = CMD_WRITE;
      else if (r < 45) b.cmd = CMD_CLEAR;
      else if (r < 48) b.cmd = CMD_CLEAR_BLK;
      else b.cmd = CMD_QUERY;
      r = $urandom;
      b.slot = r[SLOT_BITS-1:0];
      b.kind = r[SLOT_BITS+KIND_BITS-1:SLOT_BITS];
      b.pos_x = rand_coord();
      b.pos_y = rand_coord();
      b.width = rand_size(250);
      b.height = rand_size(250);
      b.inset_x = ($urandom_range(0, 1) == 0) ? '0 : rand_size(120);
      b.inset_y = ($urandom_range(0, 1) == 0) ? '0 : rand_size(120);
      b.gap_after = 0;
      b.drain = 1'b0;
      queue_beat(b);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken != total_beats) @(posedge clk);
    while (hit_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("rect_table_overlap_query: match");
    end else begin
      $display("rect_table_overlap_query: mismatch");
    end
    $finish;
  end

endmodule
